/* rtl/lz78_phrase_decoder_defines.svh */
// Assertion macros shared by the phrase decoder modules.
`ifndef LZ78_PHRASE_DECODER_DEFINES_SVH
`define LZ78_PHRASE_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LZPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LZPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lz78pd_pkg.sv */
// Types and constants shared by the phrase decoder modules.
package lz78pd_pkg;

  localparam int DICT_DEPTH_DEF = 4096;
  localparam int MAX_PHRASE_DEF = 64;
  localparam int SYMBOL_W       = 8;
  localparam int PARENT_W       = 13;
  localparam int STATUS_W       = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_LONG  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_FINISH,
    S_EMIT,
    S_ERROR
  } state_t;

  typedef struct packed {
    logic    load;
    logic    walk;
    logic    rd;
    logic    store;
    logic    emit_start;
    logic    err_load;
    status_t err_code;
  } cmd_t;

  typedef struct packed {
    logic undef;
    logic p_zero;
    logic len_full;
    logic full;
    logic emit_done;
    logic out_free;
  } stat_t;

endpackage

/* rtl/lz78pd_dpath.sv */
// Datapath: dictionary RAM, phrase stack, entry count and output register.
`include "lz78_phrase_decoder_defines.svh"

module lz78pd_dpath import lz78pd_pkg::*; #(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int MAX_PHRASE = MAX_PHRASE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic [PARENT_W-1:0] parent,
  input  logic                start_new,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYMBOL_W-1:0] out_byte,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  localparam int AW   = $clog2(DICT_DEPTH);
  localparam int CW   = $clog2(DICT_DEPTH + 1);
  localparam int CMPW = (CW > PARENT_W) ? CW : PARENT_W;
  localparam int SW   = $clog2(MAX_PHRASE);
  localparam int LW   = $clog2(MAX_PHRASE + 1);

  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic [PARENT_W-1:0] par;
  } dict_entry_t;

  dict_entry_t         dict [DICT_DEPTH];
  logic [SYMBOL_W-1:0] stack [MAX_PHRASE];

  dict_entry_t         dict_rd;
  logic [SYMBOL_W-1:0] sym_r;
  logic [PARENT_W-1:0] par_r;
  logic [CW-1:0]       cnt;
  logic [LW-1:0]       len;
  logic                first;
  logic [SW-1:0]       idx;
  logic                em_more;
  logic                pv;
  logic [SYMBOL_W-1:0] sdata;
  logic                slast;
  logic                ov;
  logic [SYMBOL_W-1:0] obyte;
  logic                olast;
  status_t             ostat;

  logic [PARENT_W-1:0] p_cur;
  logic [PARENT_W-1:0] pm1;
  logic [AW-1:0]       raddr;
  logic [LW-1:0]       len_eff;
  logic [LW-1:0]       lm1;
  logic                out_free;
  logic                load_out;
  logic                issue;

  always_comb begin
    p_cur    = first ? par_r : dict_rd.par;
    pm1      = p_cur - PARENT_W'(1);
    raddr    = AW'(pm1);
    len_eff  = first ? len : len + LW'(1);
    lm1      = len - LW'(1);
    out_free = !ov || out_ready;
    load_out = pv && out_free;
    issue    = em_more && (!pv || load_out);
  end

  always_comb begin
    stat.undef     = CMPW'(par_r) > CMPW'(cnt);
    stat.p_zero    = p_cur == '0;
    stat.len_full  = len_eff >= LW'(MAX_PHRASE);
    stat.full      = cnt >= CW'(DICT_DEPTH);
    stat.emit_done = !em_more && !pv;
    stat.out_free  = out_free;
  end

  // dictionary RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      dict[cnt[AW-1:0]] <= '{sym: sym_r, par: par_r};
    end
    if (cmd.rd) begin
      dict_rd <= dict[raddr];
    end
  end

  // phrase stack, filled last byte first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stack[0] <= symbol;
    end else if (cmd.walk && !first) begin
      stack[len[SW-1:0]] <= dict_rd.sym;
    end
    if (issue) begin
      sdata <= stack[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      first   <= 1'b0;
      em_more <= 1'b0;
      pv      <= 1'b0;
      ov      <= 1'b0;
    end else begin
      if (cmd.load) begin
        sym_r <= symbol;
        par_r <= parent;
        len   <= LW'(1);
        first <= 1'b1;
        if (start_new) begin
          cnt <= '0;
        end
      end
      if (cmd.walk) begin
        first <= 1'b0;
        if (!first) begin
          len <= len + LW'(1);
        end
      end
      if (cmd.store) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.emit_start) begin
        idx     <= lm1[SW-1:0];
        em_more <= 1'b1;
      end else if (issue) begin
        slast <= idx == '0;
        if (idx == '0) begin
          em_more <= 1'b0;
        end else begin
          idx <= idx - SW'(1);
        end
      end
      if (issue) begin
        pv <= 1'b1;
      end else if (load_out) begin
        pv <= 1'b0;
      end
      if (load_out || cmd.err_load) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
      if (load_out) begin
        obyte <= sdata;
        olast <= slast;
        ostat <= ST_OK;
      end else if (cmd.err_load) begin
        obyte <= '0;
        olast <= 1'b1;
        ostat <= cmd.err_code;
      end
    end
  end

  assign out_valid = ov;
  assign out_byte  = obyte;
  assign last      = olast;
  assign status    = ostat;

  `LZPD_ASSERT_IMP(a_walk_in_range, clk, rst, cmd.rd, CMPW'(p_cur) <= CMPW'(cnt), "walk read beyond defined entries")
  `LZPD_ASSERT_IMP(a_last_ends_emit, clk, rst, load_out && slast, !em_more, "last byte shown with stack reads pending")

endmodule

/* rtl/lz78pd_ctrl.sv */
// Controller: sequences check, chain walk, store and emission of each item.
`include "lz78_phrase_decoder_defines.svh"

module lz78pd_ctrl import lz78pd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t  state, state_next;
  status_t err_code, err_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ST_OK;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.err_code  = err_code;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.undef) begin
          err_code_next = ST_UNDEF;
          state_next    = S_ERROR;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        priority if (stat.p_zero) begin
          state_next = S_FINISH;
        end else if (stat.len_full) begin
          err_code_next = ST_LONG;
          state_next    = S_ERROR;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.full) begin
          err_code_next = ST_FULL;
          state_next    = S_ERROR;
        end else begin
          cmd.store      = 1'b1;
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.emit_done) begin
          state_next = S_IDLE;
        end
      end
      S_ERROR: begin
        if (stat.out_free) begin
          cmd.err_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LZPD_ASSERT_NXT(a_accept_to_check, clk, rst, in_valid && in_ready, state == S_CHECK, "accepted item did not enter check")
  `LZPD_ASSERT_IMP(a_err_slot_free, clk, rst, cmd.err_load, stat.out_free, "error result loaded over a waiting result")
  `LZPD_ASSERT_IMP(a_store_not_full, clk, rst, cmd.store, !stat.full, "store into a full dictionary")

endmodule

/* rtl/lz78_phrase_decoder.sv */
// Top level of the streaming LZ78 phrase decoder.
// Each accepted factor (symbol, parent) is checked against the entry count, its parent
// chain is walked through the dictionary RAM one entry per cycle, the factor is stored as
// the next entry and the phrase is streamed out first byte first, last byte marked.
// A factor whose phrase is L bytes long is accepted, checked, walked through its chain
// (L - 1 dictionary reads) and stored, and its phrase is streamed through the stack read
// and the output register at one byte per cycle while the output is ready. An undefined
// parent, a phrase too long or a full table gives a single error result, marked last. An
// output stall holds the emission and the error result, and no new item is taken until
// the last result of the current one has been loaded into the output register. The
// dictionary and stack are not cleared after reset; only the entry count is, so the block
// takes items straight out of reset.
module lz78_phrase_decoder import lz78pd_pkg::*; #(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int MAX_PHRASE = MAX_PHRASE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic [PARENT_W-1:0] parent,
  input  logic                start_new,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYMBOL_W-1:0] out_byte,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  cmd_t  cmd;
  stat_t stat;

  lz78pd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lz78pd_dpath #(
    .DICT_DEPTH (DICT_DEPTH),
    .MAX_PHRASE (MAX_PHRASE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .parent    (parent),
    .start_new (start_new),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .status    (status)
  );

endmodule
